/* rtl/core/pst_pkg.sv */
// Shared definitions for the proximity slot table: mode codes, register map,
// defaults and the control bundle sent from the sequencer to the slot cells.
// No dependencies.
package pst_pkg;

    // Default table size and coordinate width
    localparam int SLOTS_DEFAULT      = 16;
    localparam int COORD_BITS_DEFAULT = 20;

    // Request modes
    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_EVENT  = 3'd1;
    localparam logic [2:0] MODE_AREA   = 3'd2;
    localparam logic [2:0] MODE_GET    = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // Slot index that selects the last event hit
    localparam logic [5:0] INDEX_LAST_HIT = 6'h3F;

    // Register map: register index is paddr[2]
    localparam int   ADDR_W           = 3;
    localparam logic REG_EVENT_RADIUS = 1'b0;

    // Event radius after reset: 20.0 in Q15.4
    localparam int EVENT_RADIUS_RESET = 320;

    // Sequencer to cell control bundle
    typedef struct packed {
        logic load_sq;    // capture squared differences
        logic commit;     // apply the request to the table
        logic op_insert;  // first free slot wins
        logic op_event;   // inclusive radius test, else strict
        logic op_clear;   // drop all valid bits
        logic rd_en;      // drive read chain from the selected cell
    } pst_ctrl_t;

endpackage

/* rtl/core/pst_cell.sv */
// One slot of the proximity slot table: stored position, valid bit, squared
// distance to the query and its link in the priority and read chains.
// Depends on pst_pkg.
module pst_cell #(
    parameter int COORD_BITS = pst_pkg::COORD_BITS_DEFAULT,
    parameter int IDX_W      = 4,
    parameter int IDX        = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pst_pkg::pst_ctrl_t           ctrl,
    input  logic signed [COORD_BITS-1:0] qx,
    input  logic signed [COORD_BITS-1:0] qy,
    input  logic signed [COORD_BITS-1:0] qz,
    input  logic [2*COORD_BITS-3:0]      r2,
    input  logic [IDX_W-1:0]             rd_idx,
    input  logic                         hit_in,
    input  logic [IDX_W-1:0]             idx_in,
    output logic                         hit_out,
    output logic [IDX_W-1:0]             idx_out,
    input  logic signed [COORD_BITS-1:0] rx_in,
    input  logic signed [COORD_BITS-1:0] ry_in,
    input  logic signed [COORD_BITS-1:0] rz_in,
    output logic signed [COORD_BITS-1:0] rx_out,
    output logic signed [COORD_BITS-1:0] ry_out,
    output logic signed [COORD_BITS-1:0] rz_out
);

    localparam int DW    = COORD_BITS + 1;
    localparam int SQ_W  = 2 * DW;
    localparam int SUM_W = SQ_W + 2;

    logic signed [COORD_BITS-1:0] x_reg, y_reg, z_reg;
    logic                         used_reg;
    logic [SQ_W-1:0]              sqx_reg, sqy_reg, sqz_reg;

    logic [DW-1:0]    dx, dy, dz;
    logic [DW-1:0]    ax, ay, az;
    logic [SQ_W-1:0]  sqx_next, sqy_next, sqz_next;
    logic [SUM_W-1:0] dist2;
    logic [SUM_W-1:0] r2_ext;
    logic             in_radius;
    logic             my_hit;
    logic             win;
    logic             rd_sel;

    // Differences and magnitudes against the query
    assign dx = {x_reg[COORD_BITS-1], x_reg} - {qx[COORD_BITS-1], qx};
    assign dy = {y_reg[COORD_BITS-1], y_reg} - {qy[COORD_BITS-1], qy};
    assign dz = {z_reg[COORD_BITS-1], z_reg} - {qz[COORD_BITS-1], qz};
    assign ax = dx[DW-1] ? (~dx + DW'(1)) : dx;
    assign ay = dy[DW-1] ? (~dy + DW'(1)) : dy;
    assign az = dz[DW-1] ? (~dz + DW'(1)) : dz;

    // Square each magnitude
    assign sqx_next = SQ_W'(ax) * SQ_W'(ax);
    assign sqy_next = SQ_W'(ay) * SQ_W'(ay);
    assign sqz_next = SQ_W'(az) * SQ_W'(az);

    // Sum squares and compare with the squared radius
    assign dist2     = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
    assign r2_ext    = SUM_W'(r2);
    assign in_radius = ctrl.op_event ? (dist2 <= r2_ext) : (dist2 < r2_ext);
    assign my_hit    = ctrl.op_insert ? !used_reg : (used_reg && in_radius);

    // Priority chain: the first cell that hits claims the request
    assign win     = my_hit && !hit_in;
    assign hit_out = hit_in || my_hit;
    assign idx_out = hit_in ? idx_in : IDX_W'(IDX);

    // Read chain: the selected cell replaces the passing position
    assign rd_sel = ctrl.rd_en && (rd_idx == IDX_W'(IDX));
    assign rx_out = rd_sel ? x_reg : rx_in;
    assign ry_out = rd_sel ? y_reg : ry_in;
    assign rz_out = rd_sel ? z_reg : rz_in;

    // Hold squared differences for the compare cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.load_sq)
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            sqz_reg <= sqz_next;
        end
    end

    // Stored position and valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            used_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            if (ctrl.op_clear)
            begin
                used_reg <= 1'b0;
            end
            else if (ctrl.op_insert && win)
            begin
                x_reg    <= qx;
                y_reg    <= qy;
                z_reg    <= qz;
                used_reg <= 1'b1;
            end
        end
    end

endmodule

/* rtl/core/proximity_slot_table.sv */
// Top level of the proximity slot table: request sequencer, configuration
// port, result register and the row of pst_cell slots.
// Depends on pst_pkg and pst_cell.
//
// Usage:
//   A request (mode, position, area radius, slot index) enters on the
//   in_valid/in_stall channel; one result (found, slot, position) leaves on
//   the out_valid/out_stall channel for every request.
//   Each request passes a square state, in which every cell squares its
//   coordinate differences to the query, and a compare state, in which the
//   cells sum and compare, the priority chain across the row picks the first
//   hit, the table is updated and the result register is loaded. A new
//   request is taken in the cycle the previous one completes, that is while
//   the previous one is still in its compare state.
//   While the receiver stalls, the result register holds its value; the
//   next request is accepted and waits after its square stage until the
//   result register frees up.
//   Reset empties the table, zeroes all stored positions, drops the last
//   event hit and sets the event radius to 20.0 (Q15.4). The user must write
//   it via APB address 0 only while the block is idle; this is not enforced.
module proximity_slot_table #(
    parameter int SLOTS      = pst_pkg::SLOTS_DEFAULT,
    parameter int COORD_BITS = pst_pkg::COORD_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pst_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    mode,
    input  logic signed [COORD_BITS-1:0]  pos_x,
    input  logic signed [COORD_BITS-1:0]  pos_y,
    input  logic signed [COORD_BITS-1:0]  pos_z,
    input  logic [COORD_BITS-2:0]         area_radius,
    input  logic signed [5:0]             slot_index,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [3:0]                    slot,
    output logic signed [COORD_BITS-1:0]  out_x,
    output logic signed [COORD_BITS-1:0]  out_y,
    output logic signed [COORD_BITS-1:0]  out_z
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW    = COORD_BITS - 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [2:0]                   mode_reg;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;
    logic [RW-1:0]                area_radius_reg;
    logic signed [5:0]            slot_index_reg;
    logic [RW-1:0]                event_radius_reg;
    logic [2*RW-1:0]              r2_reg, r2_next;
    logic [RW-1:0]                radius_sel;

    logic             hit_valid_reg, hit_valid_next;
    logic [IDX_W-1:0] hit_slot_reg, hit_slot_next;

    logic                         out_valid_reg, out_valid_next;
    logic                         found_reg, found_next;
    logic [3:0]                   slot_reg, slot_next;
    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg, out_z_reg;

    logic               in_accept;
    logic               out_free;
    logic               commit;
    logic               cfg_write;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    logic               idx_in_range;
    pst_pkg::pst_ctrl_t ctrl;

    logic                         hit_chain [SLOTS+1];
    logic [IDX_W-1:0]             idx_chain [SLOTS+1];
    logic signed [COORD_BITS-1:0] rx_chain  [SLOTS+1];
    logic signed [COORD_BITS-1:0] ry_chain  [SLOTS+1];
    logic signed [COORD_BITS-1:0] rz_chain  [SLOTS+1];

    // Handshake and sequencing
    assign out_free  = !out_valid_reg || !out_stall;
    assign commit    = (state_reg == ST_EVAL) && out_free;
    assign in_stall  = !((state_reg == ST_IDLE) || commit);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (commit)
                begin
                    state_next = in_accept ? ST_SQ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == pst_pkg::REG_EVENT_RADIUS) ? 32'(event_radius_reg) : '0;

    // Squared radius for the pending request
    assign radius_sel = (mode_reg == pst_pkg::MODE_AREA) ? area_radius_reg : event_radius_reg;
    assign r2_next    = (2*RW)'(radius_sel) * (2*RW)'(radius_sel);

    // Read selection for get position
    assign idx_in_range = !slot_index_reg[5] && ({1'b0, slot_index_reg} < 7'(SLOTS));

    always_comb
    begin
        rd_en  = 1'b0;
        rd_idx = slot_index_reg[IDX_W-1:0];
        if (mode_reg == pst_pkg::MODE_GET)
        begin
            if (slot_index_reg == pst_pkg::INDEX_LAST_HIT)
            begin
                rd_en  = hit_valid_reg;
                rd_idx = hit_slot_reg;
            end
            else
            begin
                rd_en = idx_in_range;
            end
        end
    end

    // Control bundle to the cells
    always_comb
    begin
        ctrl.load_sq   = (state_reg == ST_SQ);
        ctrl.commit    = commit;
        ctrl.op_insert = (mode_reg == pst_pkg::MODE_INSERT);
        ctrl.op_event  = (mode_reg == pst_pkg::MODE_EVENT);
        ctrl.op_clear  = (mode_reg == pst_pkg::MODE_CLEAR);
        ctrl.rd_en     = rd_en;
    end

    // Row of slot cells
    assign hit_chain[0] = 1'b0;
    assign idx_chain[0] = '0;
    assign rx_chain[0]  = '0;
    assign ry_chain[0]  = '0;
    assign rz_chain[0]  = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        pst_cell #(
            .COORD_BITS (COORD_BITS),
            .IDX_W      (IDX_W),
            .IDX        (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .qx      (qx_reg),
            .qy      (qy_reg),
            .qz      (qz_reg),
            .r2      (r2_reg),
            .rd_idx  (rd_idx),
            .hit_in  (hit_chain[i]),
            .idx_in  (idx_chain[i]),
            .hit_out (hit_chain[i+1]),
            .idx_out (idx_chain[i+1]),
            .rx_in   (rx_chain[i]),
            .ry_in   (ry_chain[i]),
            .rz_in   (rz_chain[i]),
            .rx_out  (rx_chain[i+1]),
            .ry_out  (ry_chain[i+1]),
            .rz_out  (rz_chain[i+1])
        );
    end

    // Result and last-hit update
    always_comb
    begin
        found_next     = 1'b0;
        slot_next      = '0;
        hit_valid_next = hit_valid_reg;
        hit_slot_next  = hit_slot_reg;
        case (mode_reg)
            pst_pkg::MODE_INSERT:
            begin
                found_next = hit_chain[SLOTS];
                if (hit_chain[SLOTS])
                begin
                    slot_next = 4'(idx_chain[SLOTS]);
                end
            end
            pst_pkg::MODE_EVENT:
            begin
                found_next     = hit_chain[SLOTS];
                hit_valid_next = hit_chain[SLOTS];
                hit_slot_next  = '0;
                if (hit_chain[SLOTS])
                begin
                    slot_next     = 4'(idx_chain[SLOTS]);
                    hit_slot_next = idx_chain[SLOTS];
                end
            end
            pst_pkg::MODE_AREA:
            begin
                found_next = !hit_chain[SLOTS];
            end
            pst_pkg::MODE_GET:
            begin
                found_next = rd_en;
            end
            pst_pkg::MODE_CLEAR:
            begin
                found_next     = 1'b1;
                hit_valid_next = 1'b0;
                hit_slot_next  = '0;
            end
            default:
            begin
                found_next = 1'b0;
            end
        endcase
    end

    assign out_valid_next = commit || (out_valid_reg && out_stall);

    // Control state, configuration and last hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            hit_valid_reg    <= 1'b0;
            hit_slot_reg     <= '0;
            event_radius_reg <= RW'(pst_pkg::EVENT_RADIUS_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                hit_valid_reg <= hit_valid_next;
                hit_slot_reg  <= hit_slot_next;
            end
            if (cfg_write && (paddr[2] == pst_pkg::REG_EVENT_RADIUS))
            begin
                event_radius_reg <= pwdata[RW-1:0];
            end
        end
    end

    // Request capture, squared radius and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg        <= mode;
            qx_reg          <= pos_x;
            qy_reg          <= pos_y;
            qz_reg          <= pos_z;
            area_radius_reg <= area_radius;
            slot_index_reg  <= slot_index;
        end
        if (state_reg == ST_SQ)
        begin
            r2_reg <= r2_next;
        end
        if (commit)
        begin
            found_reg <= found_next;
            slot_reg  <= slot_next;
            out_x_reg <= rx_chain[SLOTS];
            out_y_reg <= ry_chain[SLOTS];
            out_z_reg <= rz_chain[SLOTS];
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign slot      = slot_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;

    // Checks on sequencing and result coding
    a_accept_to_sq: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_SQ))
        else $error("accepted request did not enter the square stage");

    a_sq_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ) |=> (state_reg == ST_EVAL))
        else $error("square stage not followed by compare stage");

    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("completed request left no result");

    a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (slot_reg == 4'd0))
        else $error("result without a find carries a slot number");

endmodule

/* bench/pst_checker.sv */
// Result checker for the proximity slot table: tracks the event radius from the
// APB port, predicts one answer per accepted request and compares the result stream.
// Depends on pst_pkg.
module pst_checker
    import pst_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ADDR_W-1:0]              paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           pready,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [2:0]                     mode,
    input  logic signed [COORD_BITS_DEFAULT-1:0] pos_x,
    input  logic signed [COORD_BITS_DEFAULT-1:0] pos_y,
    input  logic signed [COORD_BITS_DEFAULT-1:0] pos_z,
    input  logic [COORD_BITS_DEFAULT-2:0]  area_radius,
    input  logic signed [5:0]              slot_index,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           found,
    input  logic [3:0]                     slot,
    input  logic signed [COORD_BITS_DEFAULT-1:0] out_x,
    input  logic signed [COORD_BITS_DEFAULT-1:0] out_y,
    input  logic signed [COORD_BITS_DEFAULT-1:0] out_z,
    output int                             fail_count,
    output int                             answers_due
);

    localparam int CB    = COORD_BITS_DEFAULT;
    localparam int NSLOT = SLOTS_DEFAULT;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic                 found;
        logic [3:0]           slot;
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
    } table_answer_t;

    // Shadow copy of the table and the last event hit
    logic signed [CB-1:0] cell_x [NSLOT];
    logic signed [CB-1:0] cell_y [NSLOT];
    logic signed [CB-1:0] cell_z [NSLOT];
    logic                 cell_used [NSLOT];
    logic                 hit_valid;
    logic [3:0]           hit_slot;
    logic [CB-2:0]        radius_cfg;

    table_answer_t answer_q[$];
    int            fails;

    // Squared distance from a stored cell to the query point
    function automatic longint sq_dist(input int k, input logic signed [CB-1:0] qx,
                                       input logic signed [CB-1:0] qy,
                                       input logic signed [CB-1:0] qz);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'($signed(cell_x[k])) - longint'($signed(qx));
        dy = longint'($signed(cell_y[k])) - longint'($signed(qy));
        dz = longint'($signed(cell_z[k])) - longint'($signed(qz));
        return dx * dx + dy * dy + dz * dz;
    endfunction

    // Apply one request to the shadow table and form its answer
    task automatic predict_answer(input logic [2:0] m, input logic signed [CB-1:0] qx,
                                  input logic signed [CB-1:0] qy,
                                  input logic signed [CB-1:0] qz,
                                  input logic [CB-2:0] ar, input logic signed [5:0] idx,
                                  output table_answer_t a);
        longint r2;
        int     k;
        int     pick;
        bit     done;
        a    = '0;
        done = 1'b0;
        pick = -1;
        case (m)
            MODE_INSERT:
            begin
                for (k = 0; k < NSLOT && !done; k++)
                begin
                    if (!cell_used[k])
                    begin
                        cell_x[k]    = qx;
                        cell_y[k]    = qy;
                        cell_z[k]    = qz;
                        cell_used[k] = 1'b1;
                        a.found      = 1'b1;
                        a.slot       = 4'(k);
                        done         = 1'b1;
                    end
                end
            end
            MODE_EVENT:
            begin
                r2        = longint'(radius_cfg) * longint'(radius_cfg);
                hit_valid = 1'b0;
                hit_slot  = '0;
                for (k = 0; k < NSLOT && !done; k++)
                begin
                    if (cell_used[k] && sq_dist(k, qx, qy, qz) <= r2)
                    begin
                        hit_valid = 1'b1;
                        hit_slot  = 4'(k);
                        a.found   = 1'b1;
                        a.slot    = 4'(k);
                        done      = 1'b1;
                    end
                end
            end
            MODE_AREA:
            begin
                // strict test: a cell exactly on the radius leaves the area clear
                r2      = longint'(ar) * longint'(ar);
                a.found = 1'b1;
                for (k = 0; k < NSLOT; k++)
                begin
                    if (cell_used[k] && sq_dist(k, qx, qy, qz) < r2)
                        a.found = 1'b0;
                end
            end
            MODE_GET:
            begin
                if (idx == INDEX_LAST_HIT)
                begin
                    if (hit_valid)
                        pick = int'(hit_slot);
                end
                else if (idx >= 0 && idx < NSLOT)
                begin
                    pick = int'(idx);
                end
                // free cells are read as stored, valid bit ignored
                if (pick >= 0)
                begin
                    a.found = 1'b1;
                    a.x     = cell_x[pick];
                    a.y     = cell_y[pick];
                    a.z     = cell_z[pick];
                end
            end
            MODE_CLEAR:
            begin
                for (k = 0; k < NSLOT; k++)
                    cell_used[k] = 1'b0;
                hit_valid = 1'b0;
                hit_slot  = '0;
                a.found   = 1'b1;
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        table_answer_t want;
        table_answer_t got;
        if (!rst_n)
        begin
            for (int k = 0; k < NSLOT; k++)
            begin
                cell_x[k]    = '0;
                cell_y[k]    = '0;
                cell_z[k]    = '0;
                cell_used[k] = 1'b0;
            end
            hit_valid  = 1'b0;
            hit_slot   = '0;
            radius_cfg = (CB-1)'(EVENT_RADIUS_RESET);
            answer_q.delete();
            fails      = 0;
        end
        else
        begin
            // track register writes
            if (psel && penable && pwrite && pready && paddr[2] == REG_EVENT_RADIUS)
                radius_cfg = pwdata[CB-2:0];

            // compare the result leaving this edge with the oldest answer
            if (out_valid && !out_stall)
            begin
                got = '{found, slot, out_x, out_y, out_z};
                if (answer_q.size() == 0)
                begin
                    if (fails < REPORT_MAX)
                        $display("unexpected result: found=%0d slot=%0d pos=(%0d,%0d,%0d)",
                                 found, slot, out_x, out_y, out_z);
                    fails++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (got.found !== want.found || got.slot !== want.slot ||
                        got.x !== want.x || got.y !== want.y || got.z !== want.z)
                    begin
                        if (fails < REPORT_MAX)
                        begin
                            $write("mismatch: expected found=%0d slot=%0d pos=(%0d,%0d,%0d)",
                                   want.found, want.slot, want.x, want.y, want.z);
                            $display(" got found=%0d slot=%0d pos=(%0d,%0d,%0d)",
                                     got.found, got.slot, got.x, got.y, got.z);
                        end
                        fails++;
                    end
                end
            end

            // predict the answer of a request accepted this edge
            if (in_valid && !in_stall)
            begin
                predict_answer(mode, pos_x, pos_y, pos_z, area_radius, slot_index, want);
                answer_q.push_back(want);
            end
        end
        answers_due <= answer_q.size();
        fail_count  <= fails;
    end

endmodule

/* bench/proximity_slot_table_tb.sv */
// Top of the proximity slot table bench: clock, reset, APB writes, request and
// result drivers, and the verdict. Depends on pst_pkg, proximity_slot_table, pst_checker.
module proximity_slot_table_tb;
    import pst_pkg::*;

    localparam int CB          = COORD_BITS_DEFAULT;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_ITEMS = 190;
    localparam int PHASES      = 5;
    localparam int SQUEEZE_LEN = 80;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_stall;
    logic [2:0]           mode;
    logic signed [CB-1:0] pos_x;
    logic signed [CB-1:0] pos_y;
    logic signed [CB-1:0] pos_z;
    logic [CB-2:0]        area_radius;
    logic signed [5:0]    slot_index;
    logic                 out_valid;
    logic                 out_stall;
    logic                 found;
    logic [3:0]           slot;
    logic signed [CB-1:0] out_x;
    logic signed [CB-1:0] out_y;
    logic signed [CB-1:0] out_z;
    int                   fail_count;
    int                   answers_due;

    // Shared control between the request side and the result side
    logic calm;
    logic squeeze_go;

    // Positions already inserted, reused to aim queries near stored cells
    logic signed [CB-1:0] placed_x [16];
    logic signed [CB-1:0] placed_y [16];
    logic signed [CB-1:0] placed_z [16];
    int                   placed_n;
    logic signed [CB-1:0] anchor_x;
    logic signed [CB-1:0] anchor_y;
    logic signed [CB-1:0] anchor_z;

    localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

    proximity_slot_table dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .area_radius(area_radius), .slot_index(slot_index),
        .out_valid(out_valid), .out_stall(out_stall), .found(found), .slot(slot),
        .out_x(out_x), .out_y(out_y), .out_z(out_z)
    );

    pst_checker watch (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .area_radius(area_radius), .slot_index(slot_index),
        .out_valid(out_valid), .out_stall(out_stall), .found(found), .slot(slot),
        .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .fail_count(fail_count), .answers_due(answers_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one request and hold it until accepted
    task automatic send_req(input logic [2:0] m, input logic signed [CB-1:0] x,
                            input logic signed [CB-1:0] y, input logic signed [CB-1:0] z,
                            input logic [CB-2:0] r, input logic [5:0] idx);
        in_valid    = 1'b1;
        mode        = m;
        pos_x       = x;
        pos_y       = y;
        pos_z       = z;
        area_radius = r;
        slot_index  = idx;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (m == MODE_INSERT) begin
            placed_x[placed_n % 16] = x;
            placed_y[placed_n % 16] = y;
            placed_z[placed_n % 16] = z;
            placed_n++;
        end
    endtask

    // Drop valid for a random gap now and then, but not while calm
    task automatic maybe_idle();
        if (!calm && $urandom_range(99) < 23) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // Wait for the block to drain, then write the event radius
    task automatic set_event_radius(input logic [31:0] value);
        in_valid = 1'b0;
        wait (answers_due == 0);
        repeat (3) @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {REG_EVENT_RADIUS, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic signed [CB-1:0] near(input logic signed [CB-1:0] c,
                                                  input int span);
        int off;
        off = int'($urandom_range(2 * span)) - span;
        return c + CB'(off);
    endfunction

    function automatic int pick_span();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 8;
            2:       return 200;
            default: return 3000;
        endcase
    endfunction

    // Build one random request, mostly aimed near stored cells
    task automatic random_req();
        int                   r;
        int                   k;
        int                   span;
        logic [2:0]           m;
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
        logic [CB-2:0]        ar;
        logic [5:0]           idx;
        r = $urandom_range(99);
        if (r < 30)      m = MODE_INSERT;
        else if (r < 56) m = MODE_EVENT;
        else if (r < 74) m = MODE_AREA;
        else if (r < 95) m = MODE_GET;
        else if (r < 97) m = MODE_CLEAR;
        else             m = 3'($urandom_range(5, 7));

        r    = $urandom_range(99);
        span = pick_span();
        if (r < 55 && placed_n > 0) begin
            k = $urandom_range(((placed_n < 16) ? placed_n : 16) - 1);
            x = near(placed_x[k], span);
            y = near(placed_y[k], span);
            z = near(placed_z[k], span);
        end else if (r < 85) begin
            x = near(anchor_x, span);
            y = near(anchor_y, span);
            z = near(anchor_z, span);
        end else begin
            x = CB'($urandom());
            y = CB'($urandom());
            z = CB'($urandom());
        end

        r = $urandom_range(99);
        if (r < 50)      ar = (CB-1)'($urandom_range(800));
        else if (r < 85) ar = (CB-1)'($urandom_range(8000));
        else             ar = (CB-1)'($urandom());

        r = $urandom_range(99);
        if (r < 30)      idx = INDEX_LAST_HIT;
        else if (r < 85) idx = 6'($urandom_range(15));
        else             idx = 6'($urandom());

        send_req(m, x, y, z, ar, idx);
    endtask

    // Result side: random stall, one long hold-off when asked
    initial
    begin
        logic squeezed;
        squeezed  = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (squeeze_go && !squeezed) begin
                squeezed  = 1'b1;
                out_stall = 1'b1;
                repeat (SQUEEZE_LEN) @(negedge clk);
            end else begin
                out_stall = !calm && ($urandom_range(99) < 23);
            end
        end
    end

    // Abort when nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [31:0] radii [PHASES];
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        mode        = MODE_INSERT;
        pos_x       = '0;
        pos_y       = '0;
        pos_z       = '0;
        area_radius = '0;
        slot_index  = '0;
        calm        = 1'b0;
        squeeze_go  = 1'b0;
        placed_n    = 0;
        anchor_x    = '0;
        anchor_y    = '0;
        anchor_z    = '0;

        // hold reset, then release it
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty table, free cell read, no last hit
        send_req(MODE_GET, '0, '0, '0, '0, 6'd15);
        maybe_idle();
        send_req(MODE_GET, '0, '0, '0, '0, INDEX_LAST_HIT);
        send_req(MODE_EVENT, '0, '0, '0, '0, '0);

        // fill the table, extremes first, then one insert too many
        send_req(MODE_INSERT, '0, '0, '0, '0, '0);
        send_req(MODE_INSERT, C_MAX, C_MAX, C_MAX, '0, '0);
        maybe_idle();
        send_req(MODE_INSERT, C_MIN, C_MIN, C_MIN, '0, '0);
        for (int i = 3; i < 16; i++) begin
            maybe_idle();
            send_req(MODE_INSERT, CB'($urandom()), CB'($urandom()), CB'($urandom()),
                     '0, '0);
        end
        send_req(MODE_INSERT, 20'sd5, 20'sd5, 20'sd5, '0, '0);

        // radius boundaries: inclusive for events, strict for areas
        send_req(MODE_EVENT, 20'sd320, '0, '0, '0, '0);
        send_req(MODE_GET, '0, '0, '0, '0, INDEX_LAST_HIT);
        send_req(MODE_AREA, 20'sd320, '0, '0, 19'd320, '0);
        send_req(MODE_AREA, C_MAX, C_MIN, '0, {(CB-1){1'b1}}, '0);
        send_req(MODE_EVENT, 20'sd321, '0, '0, '0, '0);
        maybe_idle();

        // out of range indexes and unused modes
        send_req(MODE_GET, '0, '0, '0, '0, 6'd16);
        send_req(MODE_GET, '0, '0, '0, '0, 6'h3E);
        send_req(3'd5, C_MAX, C_MAX, C_MAX, {(CB-1){1'b1}}, 6'h3F);
        send_req(3'd7, C_MIN, C_MIN, C_MIN, {(CB-1){1'b1}}, 6'h20);

        // clear, then read a stale cell
        send_req(MODE_CLEAR, '0, '0, '0, '0, '0);
        send_req(MODE_GET, '0, '0, '0, '0, 6'd1);

        // random phases, one event radius each
        radii[0] = 32'hFFF8_0140;
        radii[1] = 32'd0;
        radii[2] = 32'd524287;
        radii[3] = 32'd37;
        radii[4] = 32'($urandom_range(16, 3000));
        for (int p = 0; p < PHASES; p++) begin
            set_event_radius(radii[p]);
            anchor_x = CB'($urandom());
            anchor_y = CB'($urandom());
            anchor_z = CB'($urandom());
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                calm = (p == 2 && i >= 40 && i < 150);
                if (p == 1 && i == 60)
                    squeeze_go = 1'b1;
                maybe_idle();
                random_req();
            end
        end

        // drain and give the verdict
        in_valid = 1'b0;
        calm     = 1'b0;
        wait (answers_due == 0);
        repeat (6) @(posedge clk);
        if (fail_count == 0 && answers_due == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
